[hw/rtl/sllru_pkg.sv]
`timescale 1ns / 1ps
package sllru_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int EVICT_MAX   = 16;
  localparam int EV_W        = $clog2(EVICT_MAX + 1);
  localparam int EVI_W       = $clog2(EVICT_MAX);
  localparam int Q_DEPTH     = 2;
  localparam int QP_W        = $clog2(Q_DEPTH);
  localparam int QC_W        = $clog2(Q_DEPTH + 1);
  localparam logic [30:0] MAX_BYTES_RST = 31'd33554432;
  localparam logic [30:0] BYTES_SAT     = 31'h7FFFFFFF;

  // func codes on the input word
  localparam logic [2:0] FN_ACCESS  = 3'd0;
  localparam logic [2:0] FN_REQUEST = 3'd1;
  localparam logic [2:0] FN_FILL    = 3'd2;
  localparam logic [2:0] FN_FAIL    = 3'd3;
  localparam logic [2:0] FN_QUERY   = 3'd4;
  localparam logic [2:0] FN_CLEAR   = 3'd5;

  // entry load state
  localparam logic [1:0] ES_IDLE    = 2'd0;
  localparam logic [1:0] ES_LOADING = 2'd1;
  localparam logic [1:0] ES_LOADED  = 2'd2;
  localparam logic [1:0] ES_FAILED  = 2'd3;

  // reply status
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_IGNORED = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_EVICT = 1'b1;

  typedef enum logic [2:0] {
    OP_ACCESS, OP_REQUEST, OP_FILL, OP_FAIL, OP_QUERY, OP_CLEAR, OP_OTHER
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_APPLY, S_EVCHK, S_EVSCAN, S_EVDO, S_OUT
  } eng_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key;
    logic [31:0] time_ms;
    logic [26:0] entry_bytes;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] key_out;
    logic        hit;
    logic [1:0]  state_out;
    logic [1:0]  status;
    logic [30:0] total_bytes;
    logic        last;
  } out_word_t;

  typedef struct packed {
    op_t      op;
    in_word_t word;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    logic        pop;
  } queue_ctl_t;

  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  state;
    logic [31:0] time_ms;
    logic [26:0] bytes;
  } entry_t;

endpackage

[hw/rtl/sllru_ram.sv]
`timescale 1ns / 1ps
module sllru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/sllru_front.sv]
`timescale 1ns / 1ps
module sllru_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sllru_pkg::in_word_t   in_word,
  output sllru_pkg::queue_ctl_t q_stat,
  input  logic                  q_pop,
  output sllru_pkg::queue_item_t q_item
);

  sllru_pkg::queue_item_t      mem [sllru_pkg::Q_DEPTH];
  logic [sllru_pkg::QP_W-1:0]  wp;
  logic [sllru_pkg::QP_W-1:0]  rp;
  logic [sllru_pkg::QC_W-1:0]  count;
  logic                        push;
  logic                        pop;
  sllru_pkg::op_t              op_dec;

  // classify the operation code
  always_comb begin
    unique case (in_word.func)
      sllru_pkg::FN_ACCESS:  op_dec = sllru_pkg::OP_ACCESS;
      sllru_pkg::FN_REQUEST: op_dec = sllru_pkg::OP_REQUEST;
      sllru_pkg::FN_FILL:    op_dec = sllru_pkg::OP_FILL;
      sllru_pkg::FN_FAIL:    op_dec = sllru_pkg::OP_FAIL;
      sllru_pkg::FN_QUERY:   op_dec = sllru_pkg::OP_QUERY;
      sllru_pkg::FN_CLEAR:   op_dec = sllru_pkg::OP_CLEAR;
      default:               op_dec = sllru_pkg::OP_OTHER;
    endcase
  end

  assign in_stall     = (count == sllru_pkg::QC_W'(sllru_pkg::Q_DEPTH));
  assign push         = in_valid && !in_stall;
  assign pop          = q_pop && (count != '0);
  assign q_stat.valid = (count != '0);
  assign q_stat.pop   = pop;
  assign q_item       = mem[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{op: op_dec, word: in_word};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/sllru_engine.sv]
`timescale 1ns / 1ps
module sllru_engine #(
  parameter int ENTRIES = sllru_pkg::ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [30:0]            max_total_bytes,
  input  sllru_pkg::queue_ctl_t  q_stat,
  output logic                   q_pop,
  input  sllru_pkg::queue_item_t q_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sllru_pkg::out_word_t   out_word
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  sllru_pkg::eng_state_t state, state_next;
  sllru_pkg::queue_item_t cur;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_m1;
  logic [IW-1:0]         di;
  logic [ENTRIES-1:0]    slot_valid;
  logic [30:0]           total;

  logic                  fnd;
  logic [IW-1:0]         fidx;
  logic [1:0]            fstate;
  logic [31:0]           ftime;
  logic [26:0]           fbytes;
  logic                  free_fnd;
  logic [IW-1:0]         free_idx;

  logic                  best_fnd;
  logic [IW-1:0]         best_idx;
  logic [31:0]           best_time;
  logic [26:0]           best_bytes;
  logic [31:0]           best_key;

  logic [sllru_pkg::EV_W-1:0] nev;
  logic [sllru_pkg::EV_W-1:0] oidx;
  logic [31:0]           evbuf [sllru_pkg::EVICT_MAX];

  logic                  rep_hit;
  logic [1:0]            rep_st;
  logic [1:0]            rep_status;

  logic                  we;
  logic [IW-1:0]         waddr;
  sllru_pkg::entry_t     wdata;
  sllru_pkg::entry_t     rdata;
  logic [ENTRIES*0+93-1:0] rdata_raw;

  logic                  scan_done;
  logic                  out_load;
  logic                  set_valid;
  logic                  run_evict;
  logic [31:0]           fill_sum;
  logic [30:0]           total_apply;
  logic [1:0]            st_apply;
  logic [1:0]            status_apply;
  logic                  hit_apply;
  logic [IW-1:0]         slot_sel;
  logic                  slot_ok;
  sllru_pkg::out_word_t  word_next;
  logic [sllru_pkg::EV_W-1:0] oidx_m1;

  sllru_ram #(
    .WIDTH($bits(sllru_pkg::entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt[IW-1:0]),
    .rdata(rdata_raw)
  );

  assign rdata     = rdata_raw;
  assign cnt_m1    = cnt - CW'(1);
  assign di        = cnt_m1[IW-1:0];
  assign scan_done = (cnt == CW'(ENTRIES));
  assign oidx_m1   = oidx - 1'b1;
  assign out_load  = (state == sllru_pkg::S_OUT) && (!out_valid || !out_stall);

  // table update decided once the lookup scan is over
  always_comb begin
    fill_sum     = {1'b0, total} + 32'(cur.word.entry_bytes);
    slot_ok      = fnd || free_fnd;
    slot_sel     = fnd ? fidx : free_idx;
    we           = 1'b0;
    waddr        = slot_sel;
    wdata        = '{key: cur.word.key, state: fstate, time_ms: ftime, bytes: fbytes};
    set_valid    = 1'b0;
    run_evict    = 1'b0;
    total_apply  = total;
    hit_apply    = 1'b0;
    st_apply     = fnd ? fstate : sllru_pkg::ES_IDLE;
    status_apply = sllru_pkg::STS_DONE;
    unique case (cur.op)
      sllru_pkg::OP_ACCESS: begin
        if (fnd && fstate == sllru_pkg::ES_LOADED) begin
          we            = 1'b1;
          wdata.time_ms = cur.word.time_ms;
          hit_apply     = 1'b1;
        end
      end
      sllru_pkg::OP_REQUEST: begin
        if (fnd && (fstate == sllru_pkg::ES_LOADED || fstate == sllru_pkg::ES_LOADING)) begin
          status_apply = sllru_pkg::STS_IGNORED;
        end else if (!slot_ok) begin
          status_apply = sllru_pkg::STS_FULL;
        end else begin
          we        = 1'b1;
          set_valid = 1'b1;
          wdata     = '{key: cur.word.key, state: sllru_pkg::ES_LOADING,
                        time_ms: cur.word.time_ms, bytes: '0};
          st_apply  = sllru_pkg::ES_LOADING;
        end
      end
      sllru_pkg::OP_FILL: begin
        if (fnd && fstate == sllru_pkg::ES_LOADED) begin
          we            = 1'b1;
          wdata.time_ms = cur.word.time_ms;
          status_apply  = sllru_pkg::STS_IGNORED;
        end else if (!slot_ok) begin
          status_apply = sllru_pkg::STS_FULL;
        end else begin
          we          = 1'b1;
          set_valid   = 1'b1;
          wdata       = '{key: cur.word.key, state: sllru_pkg::ES_LOADED,
                          time_ms: cur.word.time_ms, bytes: cur.word.entry_bytes};
          total_apply = fill_sum[31] ? sllru_pkg::BYTES_SAT : fill_sum[30:0];
          st_apply    = sllru_pkg::ES_LOADED;
          run_evict   = 1'b1;
        end
      end
      sllru_pkg::OP_FAIL: begin
        if (fnd && fstate != sllru_pkg::ES_LOADED) begin
          we          = 1'b1;
          wdata.state = sllru_pkg::ES_FAILED;
          wdata.bytes = '0;
          st_apply    = sllru_pkg::ES_FAILED;
        end else begin
          status_apply = sllru_pkg::STS_IGNORED;
        end
      end
      sllru_pkg::OP_QUERY: begin
      end
      sllru_pkg::OP_CLEAR: begin
        total_apply = '0;
        st_apply    = sllru_pkg::ES_IDLE;
      end
      default: begin
        status_apply = sllru_pkg::STS_IGNORED;
      end
    endcase
    if (state != sllru_pkg::S_APPLY) begin
      we = 1'b0;
    end
  end

  // result word to load
  always_comb begin
    if (oidx == '0) begin
      word_next = '{kind: sllru_pkg::KIND_REPLY, key_out: cur.word.key, hit: rep_hit,
                    state_out: rep_st, status: rep_status, total_bytes: total,
                    last: (nev == '0)};
    end else begin
      word_next = '{kind: sllru_pkg::KIND_EVICT, key_out: evbuf[oidx_m1[sllru_pkg::EVI_W-1:0]],
                    hit: 1'b0, state_out: sllru_pkg::ES_IDLE, status: sllru_pkg::STS_DONE,
                    total_bytes: total, last: (oidx == nev)};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      sllru_pkg::S_IDLE: begin
        if (q_stat.valid) begin
          q_pop      = 1'b1;
          state_next = sllru_pkg::S_LOOK;
        end
      end
      sllru_pkg::S_LOOK: begin
        if (scan_done) state_next = sllru_pkg::S_APPLY;
      end
      sllru_pkg::S_APPLY: begin
        state_next = run_evict ? sllru_pkg::S_EVCHK : sllru_pkg::S_OUT;
      end
      sllru_pkg::S_EVCHK: begin
        if (nev < sllru_pkg::EV_W'(sllru_pkg::EVICT_MAX) && total > max_total_bytes) begin
          state_next = sllru_pkg::S_EVSCAN;
        end else begin
          state_next = sllru_pkg::S_OUT;
        end
      end
      sllru_pkg::S_EVSCAN: begin
        if (scan_done) state_next = sllru_pkg::S_EVDO;
      end
      sllru_pkg::S_EVDO: begin
        state_next = best_fnd ? sllru_pkg::S_EVCHK : sllru_pkg::S_OUT;
      end
      sllru_pkg::S_OUT: begin
        if (out_load && word_next.last) state_next = sllru_pkg::S_IDLE;
      end
      default: state_next = sllru_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sllru_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers: slot valid bits, byte total, output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == sllru_pkg::S_APPLY) begin
        total <= total_apply;
        if (cur.op == sllru_pkg::OP_CLEAR) begin
          slot_valid <= '0;
        end else if (set_valid) begin
          slot_valid[slot_sel] <= 1'b1;
        end
      end
      if (state == sllru_pkg::S_EVDO && best_fnd) begin
        slot_valid[best_idx] <= 1'b0;
        total <= (31'(best_bytes) > total) ? '0 : total - 31'(best_bytes);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers of the current operation
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= word_next;
      oidx     <= oidx + 1'b1;
    end
    unique case (state)
      sllru_pkg::S_IDLE: begin
        cur      <= q_item;
        cnt      <= '0;
        fnd      <= 1'b0;
        free_fnd <= 1'b0;
        nev      <= '0;
        oidx     <= '0;
      end
      sllru_pkg::S_LOOK: begin
        cnt <= cnt + 1'b1;
        if (cnt != '0) begin
          if (slot_valid[di] && rdata.key == cur.word.key && !fnd) begin
            fnd    <= 1'b1;
            fidx   <= di;
            fstate <= rdata.state;
            ftime  <= rdata.time_ms;
            fbytes <= rdata.bytes;
          end
          if (!slot_valid[di] && !free_fnd) begin
            free_fnd <= 1'b1;
            free_idx <= di;
          end
        end
      end
      sllru_pkg::S_APPLY: begin
        rep_hit    <= hit_apply;
        rep_st     <= st_apply;
        rep_status <= status_apply;
      end
      sllru_pkg::S_EVCHK: begin
        cnt      <= '0;
        best_fnd <= 1'b0;
      end
      sllru_pkg::S_EVSCAN: begin
        cnt <= cnt + 1'b1;
        if (cnt != '0 && slot_valid[di] && rdata.state != sllru_pkg::ES_LOADING &&
            (!best_fnd || rdata.time_ms < best_time)) begin
          best_fnd   <= 1'b1;
          best_idx   <= di;
          best_time  <= rdata.time_ms;
          best_bytes <= rdata.bytes;
          best_key   <= rdata.key;
        end
      end
      sllru_pkg::S_EVDO: begin
        if (best_fnd) begin
          evbuf[nev[sllru_pkg::EVI_W-1:0]] <= best_key;
          nev <= nev + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/size_bounded_lru_cache_policy_unit.sv]
`timescale 1ns / 1ps
// an operation first runs the key lookup scan over the table and applies its update;
// after a fill, while the byte total exceeds max_total_bytes, each eviction runs an
// oldest-entry scan (at most EVICT_MAX evictions); then the result words go out
// the engine handles one operation at a time, using the one-read table RAM for its scans
// a two-word input queue takes new words while the engine works or a result waits
// reset (rst, synchronous, active high) empties the table, zeroes the byte total
// and sets max_total_bytes to 33554432
module size_bounded_lru_cache_policy_unit #(
  parameter int ENTRIES = sllru_pkg::ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sllru_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sllru_pkg::out_word_t out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [30:0]          cfg_data
);

  logic [30:0]            max_total_bytes;
  sllru_pkg::queue_ctl_t  q_stat;
  sllru_pkg::queue_item_t q_item;
  logic                   q_pop;

  // size limit register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_total_bytes <= sllru_pkg::MAX_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_total_bytes <= cfg_data;
    end
  end

  sllru_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word (in_word),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  sllru_engine #(
    .ENTRIES(ENTRIES)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .max_total_bytes(max_total_bytes),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word)
  );

endmodule

[hw/rtl/sllru_checker.sv]
`timescale 1ns / 1ps
module sllru_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input sllru_pkg::out_word_t out_word
);

  logic in_report;

  // inside an operation after its reply word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_report <= 1'b0;
    end else if (out_valid && !out_stall) begin
      in_report <= !out_word.last;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.kind == sllru_pkg::KIND_EVICT) == in_report)
    else $error("reply and eviction words out of order");

  a_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.kind == sllru_pkg::KIND_EVICT |->
      !out_word.hit && out_word.state_out == sllru_pkg::ES_IDLE &&
      out_word.status == sllru_pkg::STS_DONE)
    else $error("eviction word carries reply fields");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.kind == sllru_pkg::KIND_REPLY &&
      out_word.status != sllru_pkg::STS_DONE |-> out_word.last)
    else $error("evictions after an ignored or full operation");

endmodule

bind size_bounded_lru_cache_policy_unit sllru_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
